/* sv/string_to_integer_parser_top_macros.svh */
// Assertion macros for the string-to-integer parser.
// Each check is sampled on clk and is off while rst is high.
`ifndef STRING_TO_INTEGER_PARSER_TOP_MACROS_SVH
`define STRING_TO_INTEGER_PARSER_TOP_MACROS_SVH

// Same-cycle implication
`define STIP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define STIP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/stip_pkg.sv */
`default_nettype none
package stip_pkg;

  // Datapath sizes
  localparam int VALUE_BITS = 64;
  localparam int COUNT_BITS = 16;
  localparam int PROD_W     = VALUE_BITS + 7;

  localparam logic [VALUE_BITS-1:0] VALUE_MASK = '1;
  localparam logic [VALUE_BITS-1:0] SMAX_MAG   = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] SMIN_MAG   = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;

  // Bases
  localparam logic [5:0] BASE_AUTO = 6'd0;
  localparam logic [5:0] BASE_OCT  = 6'd8;
  localparam logic [5:0] BASE_DEC  = 6'd10;
  localparam logic [5:0] BASE_HEX  = 6'd16;
  localparam logic [5:0] BASE_MAX  = 6'd36;

  // Digit value of a byte that is no digit in any base
  localparam logic [5:0] DIGIT_NONE = 6'h3F;

  // Configuration register indexes
  typedef enum logic {
    REG_RADIX  = 1'b0,
    REG_SIGNED = 1'b1
  } reg_idx_t;

  // Classified character
  typedef struct packed {
    logic       start;
    logic       plus;
    logic       minus;
    logic       zero;
    logic       ex;
    logic [5:0] digit;
  } cls_t;

  // Front status
  typedef struct packed {
    logic valid;
    logic full;
  } fstat_t;

  // Back status
  typedef struct packed {
    logic take;
    logic emit;
  } bstat_t;

endpackage
`default_nettype wire

/* sv/string_to_integer_parser_top.sv */
// A terminating character's result reaches the result ports through the front
// queue write and then the back end result register.
// Throughput: one character per cycle through the combinational multiply-add; an
// unpopped result stalls the back end, and the two-entry queue then fills.
// Reset (synchronous, rst high): empties the front queue and the result register,
// parks the parser in the done state, and loads radix 10 and signed mode on.
`default_nettype none
`include "string_to_integer_parser_top_macros.svh"
module string_to_integer_parser_top import stip_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  ch,
  input  wire logic        start_req,
  input  wire logic        push,
  output logic             full,
  output logic [63:0]      result_value,
  output logic [15:0]      consumed,
  output logic             empty,
  input  wire logic        pop,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [5:0]  cfg_data
);

  logic [5:0] radix;
  logic       signed_mode;
  cls_t       item;
  fstat_t     fstat;
  bstat_t     bstat;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radix       <= BASE_DEC;
      signed_mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_RADIX:  radix       <= cfg_data;
        REG_SIGNED: signed_mode <= cfg_data[0];
        default:    radix       <= radix;
      endcase
    end
  end

  stip_front u_front (
    .clk       (clk),
    .rst       (rst),
    .ch        (ch),
    .start_req (start_req),
    .push      (push),
    .take      (bstat.take),
    .item      (item),
    .stat      (fstat)
  );

  stip_back u_back (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .item_valid   (fstat.valid),
    .radix        (radix),
    .signed_mode  (signed_mode),
    .pop          (pop),
    .empty        (empty),
    .result_value (result_value),
    .consumed     (consumed),
    .stat         (bstat)
  );

  assign full = fstat.full;

  // Checks
  `STIP_ASSERT_NOW(a_full_has_data, full, fstat.valid, "front full while queue empty")
  `STIP_ASSERT_NEXT(a_push_lands, push && !full, fstat.valid, "pushed beat not queued")
  `STIP_ASSERT_NEXT(a_pop_frees, !empty && pop && !bstat.emit, empty, "popped result not freed")

endmodule
`default_nettype wire

/* sv/stip_front.sv */
`default_nettype none
module stip_front import stip_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] ch,
  input  wire logic       start_req,
  input  wire logic       push,
  input  wire logic       take,
  output cls_t            item,
  output fstat_t          stat
);

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] LETTER_OFS = 8'd10;

  cls_t       cls;
  cls_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       full;
  logic       enq;
  logic       deq;

  // Classify the incoming byte
  always_comb begin
    cls.start = start_req;
    cls.plus  = (ch == CH_PLUS);
    cls.minus = (ch == CH_MINUS);
    cls.zero  = (ch == CH_0);
    cls.ex    = (ch == CH_X);
    if (ch inside {[CH_0:CH_9]}) begin
      cls.digit = 6'(ch - CH_0);
    end else if (ch inside {[CH_LA:CH_LZ]}) begin
      cls.digit = 6'(ch - CH_LA + LETTER_OFS);
    end else if (ch inside {[CH_UA:CH_UZ]}) begin
      cls.digit = 6'(ch - CH_UA + LETTER_OFS);
    end else begin
      cls.digit = DIGIT_NONE;
    end
  end

  assign full = (count == 2'd2);
  assign enq  = push && !full;
  assign deq  = take && (count != 2'd0);

  // Store classified beats
  always_ff @(posedge clk) begin
    if (enq) begin
      q[wr_ptr] <= cls;
    end
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (enq) begin
        wr_ptr <= !wr_ptr;
      end
      if (deq) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(enq) - 2'(deq);
    end
  end

  assign item       = q[rd_ptr];
  assign stat.valid = (count != 2'd0);
  assign stat.full  = full;

endmodule
`default_nettype wire

/* sv/stip_back.sv */
`default_nettype none
module stip_back import stip_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cls_t        item,
  input  wire logic        item_valid,
  input  wire logic [5:0]  radix,
  input  wire logic        signed_mode,
  input  wire logic        pop,
  output logic             empty,
  output logic [63:0]      result_value,
  output logic [15:0]      consumed,
  output bstat_t           stat
);

  typedef enum logic [2:0] {
    PH_DONE,
    PH_FIRST,
    PH_LEAD,
    PH_ZERO,
    PH_DIGITS
  } phase_t;

  phase_t                phase, phase_next;
  logic [VALUE_BITS-1:0] acc, acc_next;
  logic [COUNT_BITS-1:0] cnt, cnt_next;
  logic                  neg, neg_next;
  logic [5:0]            base, base_next;

  logic                  out_valid;
  logic [VALUE_BITS-1:0] out_value;
  logic [COUNT_BITS-1:0] out_count;

  logic                  take;
  logic                  run;
  logic                  fin;
  logic                  do_acc;
  logic [1:0]            inc;
  logic [COUNT_BITS:0]   cnt_sum;
  logic [PROD_W-1:0]     prod;
  logic [VALUE_BITS-1:0] lim;
  logic [VALUE_BITS-1:0] acc_base;
  logic [VALUE_BITS-1:0] value;

  assign take = item_valid && (!out_valid || pop);

  // Step the parser by one character
  always_comb begin
    phase_next = phase;
    acc_base   = acc;
    cnt_next   = cnt;
    neg_next   = neg;
    base_next  = base;
    fin        = 1'b0;
    do_acc     = 1'b0;
    inc        = 2'd0;
    run        = item.start || (phase != PH_DONE);

    if (item.start) begin
      acc_base   = '0;
      cnt_next   = '0;
      neg_next   = 1'b0;
      base_next  = radix;
      phase_next = PH_FIRST;
    end

    // Base check and sign
    if (run && phase_next == PH_FIRST) begin
      if (base_next > BASE_MAX) begin
        fin = 1'b1;
        run = 1'b0;
      end else begin
        phase_next = PH_LEAD;
        if (item.plus || item.minus) begin
          neg_next = item.minus;
          inc      = 2'd1;
          run      = 1'b0;
        end
      end
    end

    // Prefix detection
    if (run && phase_next == PH_LEAD) begin
      if (item.zero) begin
        phase_next = PH_ZERO;
        run        = 1'b0;
      end else begin
        if (base_next == BASE_AUTO) begin
          base_next = BASE_DEC;
        end
        phase_next = PH_DIGITS;
      end
    end else if (run && phase_next == PH_ZERO) begin
      if (item.ex && (base_next == BASE_AUTO || base_next == BASE_HEX)) begin
        base_next = BASE_HEX;
        inc       = 2'd2;
        run       = 1'b0;
      end else if (!item.ex && (base_next == BASE_AUTO || base_next == BASE_OCT)) begin
        base_next = BASE_OCT;
        inc       = 2'd1;
      end else begin
        // leading zero counts as a digit of value zero
        if (base_next == BASE_AUTO) begin
          base_next = BASE_DEC;
        end
        inc = 2'd1;
      end
      phase_next = PH_DIGITS;
    end

    // Digit or terminator
    if (run) begin
      if (item.digit >= base_next) begin
        fin = 1'b1;
      end else begin
        do_acc = 1'b1;
        inc    = inc + 2'd1;
      end
    end

    if (fin) begin
      phase_next = PH_DONE;
    end

    cnt_sum  = {1'b0, cnt_next} + (COUNT_BITS+1)'(inc);
    cnt_next = (cnt_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : cnt_sum[COUNT_BITS-1:0];
  end

  // Multiply-add with exact saturation, except a negative number in unsigned mode wraps
  always_comb begin
    prod = PROD_W'(acc_base) * PROD_W'(base_next) + PROD_W'(item.digit);
    if (signed_mode) begin
      lim = neg_next ? SMIN_MAG : SMAX_MAG;
    end else begin
      lim = VALUE_MASK;
    end
    acc_next = acc_base;
    if (do_acc) begin
      if (!signed_mode && neg_next) begin
        acc_next = prod[VALUE_BITS-1:0];
      end else if (prod > PROD_W'(lim)) begin
        acc_next = lim;
      end else begin
        acc_next = prod[VALUE_BITS-1:0];
      end
    end
    value = neg_next ? (VALUE_BITS'(0) - acc_next) : acc_next;
  end

  // Parser state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_DONE;
      acc       <= '0;
      cnt       <= '0;
      neg       <= 1'b0;
      base      <= BASE_AUTO;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        phase <= phase_next;
        acc   <= acc_next;
        cnt   <= cnt_next;
        neg   <= neg_next;
        base  <= base_next;
      end
      if (take && fin) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the result payload until popped
  always_ff @(posedge clk) begin
    if (take && fin) begin
      out_value <= value;
      out_count <= cnt_next;
    end
  end

  assign empty        = !out_valid;
  assign result_value = 64'(out_value);
  assign consumed     = 16'(out_count);
  assign stat.take    = take;
  assign stat.emit    = take && fin;

endmodule
`default_nettype wire
